// File: rtl/core/cdr_pkg.sv
package cdr_pkg;

  localparam int MaxContacts = 8;
  localparam int CntW = $clog2(MaxContacts + 1);
  localparam int IdxW = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;
  localparam int AccW = 72;

  localparam logic [1:0] ReqContact = 2'd0;
  localparam logic [1:0] ReqLinear  = 2'd1;
  localparam logic [1:0] ReqAngular = 2'd2;
  localparam logic [1:0] ReqEval    = 2'd3;

  localparam logic [2:0] RegMass = 3'd0;
  localparam logic [2:0] RegIxx  = 3'd1;
  localparam logic [2:0] RegIyy  = 3'd2;
  localparam logic [2:0] RegIzz  = 3'd3;
  localparam logic [2:0] RegIxy  = 3'd4;
  localparam logic [2:0] RegIxz  = 3'd5;
  localparam logic [2:0] RegIyz  = 3'd6;
  localparam logic [2:0] RegGrav = 3'd7;

  // accumulator targets
  typedef enum logic [3:0] {
    ACC_NONE, ACC_T0, ACC_T1, ACC_T2, ACC_R0, ACC_R1, ACC_R2,
    ACC_R3, ACC_R4, ACC_R5, ACC_SUBR0, ACC_SUBR1, ACC_SUBR2
  } acc_sel_t;

  // multiplier operand sources
  typedef enum logic [4:0] {
    OP_ZERO, OP_IXX, OP_IYY, OP_IZZ, OP_NIXY, OP_NIXZ, OP_NIYZ, OP_MASS, OP_GRAV,
    OP_C0, OP_C1, OP_C2, OP_A0, OP_A1, OP_A2, OP_W0, OP_W1, OP_W2,
    OP_D0, OP_D1, OP_D2, OP_T0, OP_T1, OP_T2, OP_P0, OP_P1, OP_P2,
    OP_F0, OP_F1, OP_F2
  } op_sel_t;

  typedef struct packed {
    logic     clear;      // zero all accumulators
    logic     sat_t;      // saturate iw temps
    logic     mul_en;
    op_sel_t  op_a;
    op_sel_t  op_b;
    logic     neg;        // subtract product
    logic     rdiff;      // operand b is c - p of the current contact
    acc_sel_t dst;
    logic     add_f;      // subtract current force from linear sums
    logic     rd_en;
    logic [IdxW-1:0] rd_idx;
  } dp_cmd_t;

endpackage

// File: rtl/core/centroidal_dynamics_residual.sv
// loads (contact, com, angular): accepted every cycle while no evaluation runs
// evaluate: runs on the one shared 33x33 multiplier, then the result waits
// in an output register
// the input stalls while an evaluation runs; loads are accepted while the result
// waits to be taken, a further evaluate waits until it is taken
// rst (synchronous) restores register defaults, zeroes base vectors, contact count and flag
module centroidal_dynamics_residual
  import cdr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [1:0]   s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,  // angular_x..z, linear_x..z, contact_overflow, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic busy;
  logic [CntW-1:0] count;
  logic ovf;
  logic acc_in, start, done;
  logic [191:0] res;
  dp_cmd_t cmd;

  assign s_tready = !busy && !(m_tvalid && !m_tready && s_tuser == ReqEval);
  assign acc_in = s_tvalid && s_tready;
  assign start = acc_in && s_tuser == ReqEval;
  assign cfg_ready = 1'b1;

  cdr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .count(count), .cmd(cmd), .done(done)
  );

  cdr_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .ld_lin(acc_in && s_tuser == ReqLinear),
    .ld_ang(acc_in && s_tuser == ReqAngular),
    .ct_we(acc_in && s_tuser == ReqContact && count < CntW'(MaxContacts)),
    .ct_idx(count[IdxW-1:0]),
    .vec_in(s_tdata), .cmd(cmd), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      ovf <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (start) busy <= 1'b1;
      if (acc_in && s_tuser == ReqContact) begin
        if (count < CntW'(MaxContacts)) count <= count + 1'b1;
        else ovf <= 1'b1;
      end
      if (done) begin
        busy <= 1'b0;
        m_tvalid <= 1'b1;
        count <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) m_tdata <= {7'd0, ovf, res};
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside an evaluation");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxContacts)) else $error("contact count over capacity");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("input taken during evaluation");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    $past(done) |-> m_tvalid) else $error("result lost");
endmodule

// File: rtl/core/cdr_ram.sv
module cdr_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/cdr_datapath.sv
module cdr_datapath
  import cdr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [31:0]   cfg_data,
  input  logic          ld_lin,
  input  logic          ld_ang,
  input  logic          ct_we,
  input  logic [IdxW-1:0] ct_idx,
  input  logic [191:0]  vec_in,
  input  dp_cmd_t       cmd,
  output logic [191:0]  res
);
  logic [30:0] mass, grav;
  logic signed [31:0] ixx, iyy, izz, ixy, ixz, iyz;
  logic signed [31:0] bv [12];
  logic [191:0] ct;
  logic signed [AccW-1:0] acc [9];
  logic signed [31:0] tmp [3];
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [49:0] pfl;
  logic pvalid, pneg;
  acc_sel_t pdst;
  logic signed [AccW-1:0] addend;
  logic signed [31:0] fsel;

  cdr_ram #(.Width(192), .Depth(1 << IdxW)) u_ram (
    .clk(clk), .we(ct_we), .waddr(ct_idx), .wdata(vec_in),
    .raddr(cmd.rd_idx), .rdata(ct)
  );

  function automatic logic signed [31:0] sat(input logic signed [AccW-1:0] v);
    if (v > 72'sd2147483647) return 32'h7fffffff;
    if (v < -72'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [32:0] pick(input op_sel_t s,
      input logic signed [31:0] b [12], input logic signed [31:0] t [3],
      input logic [191:0] c, input logic [30:0] m, input logic [30:0] g,
      input logic signed [31:0] xx, input logic signed [31:0] yy,
      input logic signed [31:0] zz, input logic signed [31:0] xy,
      input logic signed [31:0] xz, input logic signed [31:0] yz);
    case (s)
      OP_IXX:  return 33'(xx);
      OP_IYY:  return 33'(yy);
      OP_IZZ:  return 33'(zz);
      OP_NIXY: return -33'(xy);
      OP_NIXZ: return -33'(xz);
      OP_NIYZ: return -33'(yz);
      OP_MASS: return {2'b00, m};
      OP_GRAV: return {2'b00, g};
      OP_C0: return 33'(b[0]);  OP_C1: return 33'(b[1]);  OP_C2: return 33'(b[2]);
      OP_A0: return 33'(b[3]);  OP_A1: return 33'(b[4]);  OP_A2: return 33'(b[5]);
      OP_W0: return 33'(b[6]);  OP_W1: return 33'(b[7]);  OP_W2: return 33'(b[8]);
      OP_D0: return 33'(b[9]);  OP_D1: return 33'(b[10]); OP_D2: return 33'(b[11]);
      OP_T0: return 33'(t[0]);  OP_T1: return 33'(t[1]);  OP_T2: return 33'(t[2]);
      OP_P0: return 33'($signed(c[31:0]));
      OP_P1: return 33'($signed(c[63:32]));
      OP_P2: return 33'($signed(c[95:64]));
      OP_F0: return 33'($signed(c[127:96]));
      OP_F1: return 33'($signed(c[159:128]));
      OP_F2: return 33'($signed(c[191:160]));
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa = pick(cmd.op_a, bv, tmp, ct, mass, grav, ixx, iyy, izz, ixy, ixz, iyz);
    opb = pick(cmd.op_b, bv, tmp, ct, mass, grav, ixx, iyy, izz, ixy, ixz, iyz);
    // c - p, op_b names c index, p comes from the same lane
    if (cmd.rdiff) begin
      case (cmd.op_b)
        OP_C0: opb = 33'(bv[0]) - 33'($signed(ct[31:0]));
        OP_C1: opb = 33'(bv[1]) - 33'($signed(ct[63:32]));
        OP_C2: opb = 33'(bv[2]) - 33'($signed(ct[95:64]));
        default: ;
      endcase
    end
  end

  always_comb begin
    addend = pneg ? -AccW'(pfl) : AccW'(pfl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= 31'd65536; grav <= 31'd642908;
      ixx <= 32'sd65536; iyy <= 32'sd65536; izz <= 32'sd65536;
      ixy <= '0; ixz <= '0; iyz <= '0;
      for (int i = 0; i < 12; i++) bv[i] <= '0;
      pvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          RegMass: mass <= cfg_data[30:0];
          RegIxx:  ixx <= cfg_data;
          RegIyy:  iyy <= cfg_data;
          RegIzz:  izz <= cfg_data;
          RegIxy:  ixy <= cfg_data;
          RegIxz:  ixz <= cfg_data;
          RegIyz:  iyz <= cfg_data;
          RegGrav: grav <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (ld_lin) for (int i = 0; i < 6; i++) bv[i] <= vec_in[32*i +: 32];
      if (ld_ang) for (int i = 0; i < 6; i++) bv[6+i] <= vec_in[32*i +: 32];
      pvalid <= cmd.mul_en;
    end
  end

  // multiply stage, then floor to q16.16 and accumulate
  always_ff @(posedge clk) begin
    prod <= 66'(opa) * 66'(opb);
    pneg <= cmd.neg;
    pdst <= cmd.dst;
  end
  assign pfl = prod[65:16];

  always_comb begin
    case (cmd.op_a)
      OP_F0: fsel = $signed(ct[127:96]);
      OP_F1: fsel = $signed(ct[159:128]);
      default: fsel = $signed(ct[191:160]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < 9; i++) acc[i] <= '0;
    end else begin
      if (pvalid && pdst != ACC_NONE) begin
        case (pdst)
          ACC_T0: acc[0] <= acc[0] + addend;
          ACC_T1: acc[1] <= acc[1] + addend;
          ACC_T2: acc[2] <= acc[2] + addend;
          ACC_R0, ACC_SUBR0: acc[3] <= acc[3] + addend;
          ACC_R1, ACC_SUBR1: acc[4] <= acc[4] + addend;
          ACC_R2, ACC_SUBR2: acc[5] <= acc[5] + addend;
          ACC_R3: acc[6] <= acc[6] + addend;
          ACC_R4: acc[7] <= acc[7] + addend;
          ACC_R5: acc[8] <= acc[8] + addend;
          default: ;
        endcase
      end
      if (cmd.add_f) begin
        case (cmd.op_a)
          OP_F0: acc[6] <= acc[6] - AccW'(fsel);
          OP_F1: acc[7] <= acc[7] - AccW'(fsel);
          default: acc[8] <= acc[8] - AccW'(fsel);
        endcase
      end
    end
    if (cmd.sat_t) for (int i = 0; i < 3; i++) tmp[i] <= sat(acc[i]);
  end

  always_comb begin
    for (int i = 0; i < 6; i++) res[32*i +: 32] = sat(acc[3+i]);
  end
endmodule

// File: rtl/core/cdr_ctrl.sv
module cdr_ctrl
  import cdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [CntW-1:0] count,
  output dp_cmd_t     cmd,
  output logic        done
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_INER = 5'b00010, S_GYRO = 5'b00100,
    S_CONT = 5'b01000, S_FIN = 5'b10000
  } state_t;

  typedef struct packed {
    op_sel_t a;
    op_sel_t b;
    logic    neg;
    acc_sel_t d;
  } step_t;

  state_t state, state_next;
  logic [4:0] step, step_next;
  logic [CntW-1:0] k, k_next;
  step_t s;

  // inertia phase: iw into temps, i*wd, m*a and m*g into results
  function automatic step_t iner(input logic [4:0] n);
    case (n)
      5'd0:  return '{OP_IXX, OP_W0, 1'b0, ACC_T0};
      5'd1:  return '{OP_NIXY, OP_W1, 1'b0, ACC_T0};
      5'd2:  return '{OP_NIXZ, OP_W2, 1'b0, ACC_T0};
      5'd3:  return '{OP_NIXY, OP_W0, 1'b0, ACC_T1};
      5'd4:  return '{OP_IYY, OP_W1, 1'b0, ACC_T1};
      5'd5:  return '{OP_NIYZ, OP_W2, 1'b0, ACC_T1};
      5'd6:  return '{OP_NIXZ, OP_W0, 1'b0, ACC_T2};
      5'd7:  return '{OP_NIYZ, OP_W1, 1'b0, ACC_T2};
      5'd8:  return '{OP_IZZ, OP_W2, 1'b0, ACC_T2};
      5'd9:  return '{OP_IXX, OP_D0, 1'b0, ACC_R0};
      5'd10: return '{OP_NIXY, OP_D1, 1'b0, ACC_R0};
      5'd11: return '{OP_NIXZ, OP_D2, 1'b0, ACC_R0};
      5'd12: return '{OP_NIXY, OP_D0, 1'b0, ACC_R1};
      5'd13: return '{OP_IYY, OP_D1, 1'b0, ACC_R1};
      5'd14: return '{OP_NIYZ, OP_D2, 1'b0, ACC_R1};
      5'd15: return '{OP_NIXZ, OP_D0, 1'b0, ACC_R2};
      5'd16: return '{OP_NIYZ, OP_D1, 1'b0, ACC_R2};
      5'd17: return '{OP_IZZ, OP_D2, 1'b0, ACC_R2};
      5'd18: return '{OP_MASS, OP_A0, 1'b0, ACC_R3};
      5'd19: return '{OP_MASS, OP_A1, 1'b0, ACC_R4};
      5'd20: return '{OP_MASS, OP_A2, 1'b0, ACC_R5};
      5'd21: return '{OP_MASS, OP_GRAV, 1'b0, ACC_R5};
      default: return '{OP_ZERO, OP_ZERO, 1'b0, ACC_NONE};
    endcase
  endfunction

  function automatic step_t gyro(input logic [4:0] n);
    case (n)
      5'd0: return '{OP_W1, OP_T2, 1'b0, ACC_R0};
      5'd1: return '{OP_W2, OP_T1, 1'b1, ACC_R0};
      5'd2: return '{OP_W2, OP_T0, 1'b0, ACC_R1};
      5'd3: return '{OP_W0, OP_T2, 1'b1, ACC_R1};
      5'd4: return '{OP_W0, OP_T1, 1'b0, ACC_R2};
      5'd5: return '{OP_W1, OP_T0, 1'b1, ACC_R2};
      default: return '{OP_ZERO, OP_ZERO, 1'b0, ACC_NONE};
    endcase
  endfunction

  // tau = f x r, subtracted
  function automatic step_t cont(input logic [4:0] n);
    case (n)
      5'd1: return '{OP_F1, OP_C2, 1'b1, ACC_SUBR0};
      5'd2: return '{OP_F2, OP_C1, 1'b0, ACC_SUBR0};
      5'd3: return '{OP_F2, OP_C0, 1'b1, ACC_SUBR1};
      5'd4: return '{OP_F0, OP_C2, 1'b0, ACC_SUBR1};
      5'd5: return '{OP_F0, OP_C1, 1'b1, ACC_SUBR2};
      5'd6: return '{OP_F1, OP_C0, 1'b0, ACC_SUBR2};
      default: return '{OP_ZERO, OP_ZERO, 1'b0, ACC_NONE};
    endcase
  endfunction

  always_comb begin
    state_next = state;
    step_next = step;
    k_next = k;
    done = 1'b0;
    cmd = '0;
    cmd.op_a = OP_ZERO;
    cmd.op_b = OP_ZERO;
    cmd.dst = ACC_NONE;
    cmd.rd_idx = k[IdxW-1:0];
    s = '{OP_ZERO, OP_ZERO, 1'b0, ACC_NONE};
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          state_next = S_INER;
          step_next = '0;
        end
      end
      S_INER: begin
        s = iner(step);
        cmd.mul_en = (step <= 5'd21);
        step_next = step + 5'd1;
        // wait for the last iw term to land
        if (step == 5'd23) begin
          cmd.sat_t = 1'b1;
        end
        if (step == 5'd24) begin
          state_next = S_GYRO;
          step_next = '0;
        end
      end
      S_GYRO: begin
        s = gyro(step);
        cmd.mul_en = (step <= 5'd5);
        step_next = step + 5'd1;
        cmd.rd_idx = '0;
        if (step == 5'd5) begin
          step_next = '0;
          k_next = '0;
          state_next = (count == '0) ? S_FIN : S_CONT;
        end
      end
      S_CONT: begin
        // step 0 reads the entry, 1..6 multiply, 7..9 sum forces
        cmd.rd_en = 1'b1;
        s = cont(step);
        cmd.mul_en = (step >= 5'd1 && step <= 5'd6);
        cmd.rdiff = cmd.mul_en;
        if (step >= 5'd7) begin
          cmd.add_f = 1'b1;
          s.a = (step == 5'd7) ? OP_F0 : (step == 5'd8) ? OP_F1 : OP_F2;
        end
        step_next = step + 5'd1;
        if (step == 5'd9) begin
          step_next = '0;
          k_next = k + 1'b1;
          if (k + 1'b1 == count) state_next = S_FIN;
        end
      end
      S_FIN: begin
        // let the multiply pipe drain
        step_next = step + 5'd1;
        if (step == 5'd2) begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state != S_IDLE) begin
      cmd.op_a = s.a;
      cmd.op_b = s.b;
      cmd.neg = s.neg;
      cmd.dst = s.d;
    end
    if (state_next == S_FIN && state != S_FIN) step_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
      k <= k_next;
    end
  end
endmodule
